/* design/sas_pkg.sv */
package sas_pkg;

    // input beat command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PLAY  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_FIRST = 2'd0;
    localparam logic [1:0] REG_LAST  = 2'd1;
    localparam logic [1:0] REG_DIR   = 2'd2;
    localparam logic [1:0] REG_LOOP  = 2'd3;

    // play direction codes
    localparam logic [1:0] DIR_FWD = 2'd0;
    localparam logic [1:0] DIR_REV = 2'd1;
    localparam logic [1:0] DIR_PP  = 2'd2;

    localparam int FRAME_W  = 8;
    localparam int STEP_W   = 9;   // up to 510 ping-pong steps
    localparam int CNT_W    = 10;  // holds the step count itself
    localparam int TIME_W   = 32;
    localparam int DUR_W    = 16;
    localparam int PERIOD_W = 25;  // 510 steps of 65535 ms
    localparam int DIVC_W   = 5;   // 32 divider iterations

    typedef struct packed {
        logic capture;     // latch input beat, clear change flag
        logic do_play;     // restart tag at step 0
        logic do_write;    // store one duration entry
        logic chk;         // compare elapsed time, advance one step
        logic per_clr;     // start a period sum
        logic per_issue;   // read duration of the next period step
        logic per_done;    // period sum complete
        logic div_start;   // load remainder divider
        logic div_step;    // one restoring divide iteration
        logic skip_apply;  // drop whole loop periods
        logic out_load;    // load result register
    } sas_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       active;     // playing and not finished
        logic       loop_en;
        logic       chk_stop;   // elapsed time below current duration
        logic       chk_fin;    // advance would finish playback
        logic       per_valid;  // cached period sum is current
        logic       per_more;   // period steps left to read
        logic       skip_need;  // elapsed time covers a full period
        logic       div_last;   // final divider iteration
        logic       out_free;   // result register can take a beat
    } sas_stat_t;

endpackage

/* design/sas_ctrl.sv */
module sas_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sas_pkg::sas_stat_t  sts,
    output sas_pkg::sas_cmd_t   ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DISP    = 4'd1;
    localparam logic [3:0] S_CHK     = 4'd2;
    localparam logic [3:0] S_RD      = 4'd3;
    localparam logic [3:0] S_PER_CLR = 4'd4;
    localparam logic [3:0] S_PER_RUN = 4'd5;
    localparam logic [3:0] S_SKIP    = 4'd6;
    localparam logic [3:0] S_DIV     = 4'd7;
    localparam logic [3:0] S_APPLY   = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       skip_done_reg;
    logic       skip_done_next;

    always_comb
    begin
        ctl            = '0;
        state_next     = state_reg;
        skip_done_next = skip_done_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.capture    = 1'b1;
                    skip_done_next = 1'b0;
                    state_next     = S_DISP;
                end
            end
            S_DISP:
            begin
                case (sts.cmd)
                    sas_pkg::CMD_TICK:
                    begin
                        state_next = sts.active ? S_CHK : S_OUT;
                    end
                    sas_pkg::CMD_PLAY:
                    begin
                        ctl.do_play = 1'b1;
                        state_next  = S_OUT;
                    end
                    sas_pkg::CMD_WRITE:
                    begin
                        ctl.do_write = 1'b1;
                        state_next   = S_OUT;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end
            S_CHK:
            begin
                ctl.chk = 1'b1;
                if (sts.chk_stop || sts.chk_fin)
                begin
                    state_next = S_OUT;
                end
                else if (sts.loop_en && !skip_done_reg)
                begin
                    skip_done_next = 1'b1;
                    state_next     = sts.per_valid ? S_SKIP : S_PER_CLR;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_CHK;
            end
            S_PER_CLR:
            begin
                ctl.per_clr = 1'b1;
                state_next  = S_PER_RUN;
            end
            S_PER_RUN:
            begin
                if (sts.per_more)
                begin
                    ctl.per_issue = 1'b1;
                end
                else
                begin
                    ctl.per_done = 1'b1;
                    state_next   = S_SKIP;
                end
            end
            S_SKIP:
            begin
                if (sts.skip_need)
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                ctl.skip_apply = 1'b1;
                state_next     = S_CHK;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            skip_done_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            skip_done_reg <= skip_done_next;
        end
    end

endmodule

/* design/sas_dpath.sv */
module sas_dpath #(
    parameter int FRAME_COUNT = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [sas_pkg::FRAME_W-1:0]      cfg_data,
    input  logic [1:0]                       in_cmd,
    input  logic [sas_pkg::TIME_W-1:0]       in_now,
    input  logic [sas_pkg::FRAME_W-1:0]      in_idx,
    input  logic [sas_pkg::DUR_W-1:0]        in_dur,
    input  sas_pkg::sas_cmd_t                ctl,
    output sas_pkg::sas_stat_t               sts,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [sas_pkg::FRAME_W-1:0]      out_frame,
    output logic                             out_chg,
    output logic                             out_done
);

    localparam int AW = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam logic [sas_pkg::FRAME_W:0] FC = (sas_pkg::FRAME_W + 1)'(FRAME_COUNT);

    // configuration
    logic [7:0] first_reg;
    logic [7:0] last_reg;
    logic [1:0] dir_reg;
    logic       loop_reg;

    // captured input beat
    logic [1:0]                    cmd_reg;
    logic [sas_pkg::TIME_W-1:0]    now_reg;
    logic [sas_pkg::FRAME_W-1:0]   idx_reg;
    logic [sas_pkg::DUR_W-1:0]     dur_in_reg;

    // playback state
    logic [sas_pkg::STEP_W-1:0]    step_reg;
    logic [sas_pkg::FRAME_W-1:0]   cur_reg;
    logic [sas_pkg::TIME_W-1:0]    sst_reg;
    logic                          fin_reg;
    logic                          play_reg;
    logic                          chg_reg;

    // duration table, registered read
    logic [sas_pkg::DUR_W-1:0]     mem [FRAME_COUNT];
    logic [sas_pkg::DUR_W-1:0]     rdata_reg;
    logic                          rd_ok_reg;

    // loop period sum and remainder divider
    logic [sas_pkg::CNT_W-1:0]     ps_reg;
    logic [sas_pkg::PERIOD_W-1:0]  sum_reg;
    logic                          per_valid_reg;
    logic                          acc_pend_reg;
    logic [sas_pkg::PERIOD_W-1:0]  rem_reg;
    logic [sas_pkg::TIME_W-1:0]    dvd_reg;
    logic [sas_pkg::DIVC_W-1:0]    dcnt_reg;

    // result register
    logic                          out_valid_reg;
    logic [sas_pkg::FRAME_W-1:0]   out_frame_reg;
    logic                          out_chg_reg;
    logic                          out_done_reg;

    logic [7:0]                    eff_last;
    logic [8:0]                    span_n;
    logic [sas_pkg::CNT_W-1:0]     step_cnt;
    logic [sas_pkg::DUR_W-1:0]     dur_cur;
    logic [sas_pkg::TIME_W-1:0]    elapsed;
    logic                          stop;
    logic [sas_pkg::CNT_W-1:0]     step_p1;
    logic                          wrap_end;
    logic [sas_pkg::STEP_W-1:0]    next_step;
    logic [7:0]                    next_frame;
    logic [7:0]                    start_frame;
    logic [7:0]                    rd_addr;
    logic [sas_pkg::PERIOD_W:0]    div_shift;
    logic [sas_pkg::PERIOD_W:0]    div_sub;
    logic [sas_pkg::PERIOD_W-1:0]  rem_next;

    function automatic logic [7:0] frame_at(
        input logic [8:0] step,
        input logic [7:0] first,
        input logic [7:0] last,
        input logic [8:0] n,
        input logic [1:0] dir
    );
        logic [7:0] f;
        case (dir)
            sas_pkg::DIR_REV: f = last - step[7:0];
            sas_pkg::DIR_PP:
            begin
                if (step < n)
                begin
                    f = first + step[7:0];
                end
                else
                begin
                    f = last - step[7:0] + n[7:0] - 8'd1;
                end
            end
            default: f = first + step[7:0];
        endcase
        return f;
    endfunction

    always_comb
    begin
        eff_last = (last_reg < first_reg) ? first_reg : last_reg;
        span_n   = {1'b0, eff_last} - {1'b0, first_reg} + 9'd1;
        if (dir_reg == sas_pkg::DIR_PP && span_n > 9'd1)
        begin
            step_cnt = {span_n, 1'b0} - 10'd2;
        end
        else
        begin
            step_cnt = {1'b0, span_n};
        end

        // zero or out-of-range entry owes 1 ms
        dur_cur = (rd_ok_reg && rdata_reg != '0) ? rdata_reg : 16'd1;
        elapsed = now_reg - sst_reg;
        stop    = elapsed < {16'd0, dur_cur};

        step_p1    = {1'b0, step_reg} + 10'd1;
        wrap_end   = step_p1 >= step_cnt;
        next_step  = wrap_end ? '0 : step_p1[sas_pkg::STEP_W-1:0];
        next_frame = frame_at(next_step, first_reg, eff_last, span_n, dir_reg);
        start_frame = frame_at('0, first_reg, eff_last, span_n, dir_reg);

        rd_addr = ctl.per_issue
                ? frame_at(ps_reg[sas_pkg::STEP_W-1:0], first_reg, eff_last, span_n, dir_reg)
                : cur_reg;

        div_shift = {rem_reg, dvd_reg[sas_pkg::TIME_W-1]};
        div_sub   = div_shift - {1'b0, sum_reg};
        rem_next  = (div_shift >= {1'b0, sum_reg}) ? div_sub[sas_pkg::PERIOD_W-1:0]
                                                   : div_shift[sas_pkg::PERIOD_W-1:0];
    end

    always_comb
    begin
        sts.cmd       = cmd_reg;
        sts.active    = play_reg && !fin_reg;
        sts.loop_en   = loop_reg;
        sts.chk_stop  = stop;
        sts.chk_fin   = !stop && wrap_end && !loop_reg;
        sts.per_valid = per_valid_reg;
        sts.per_more  = ps_reg < step_cnt;
        sts.skip_need = elapsed >= {7'd0, sum_reg};
        sts.div_last  = dcnt_reg == '0;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.do_write && ({1'b0, idx_reg} < FC))
        begin
            mem[idx_reg[AW-1:0]] <= dur_in_reg;
        end
        rdata_reg <= mem[rd_addr[AW-1:0]];
        rd_ok_reg <= {1'b0, rd_addr} < FC;
    end

    // input capture, sum data, divider and result data: no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg    <= in_cmd;
            now_reg    <= in_now;
            idx_reg    <= in_idx;
            dur_in_reg <= in_dur;
        end
        if (ctl.per_clr)
        begin
            sum_reg <= '0;
            ps_reg  <= '0;
        end
        else
        begin
            if (acc_pend_reg)
            begin
                sum_reg <= sum_reg + {9'd0, dur_cur};
            end
            if (ctl.per_issue)
            begin
                ps_reg <= ps_reg + 10'd1;
            end
        end
        if (ctl.div_start)
        begin
            rem_reg  <= '0;
            dvd_reg  <= elapsed;
            dcnt_reg <= '1;
        end
        else if (ctl.div_step)
        begin
            rem_reg  <= rem_next;
            dvd_reg  <= {dvd_reg[sas_pkg::TIME_W-2:0], 1'b0};
            dcnt_reg <= dcnt_reg - 5'd1;
        end
        if (ctl.out_load)
        begin
            out_frame_reg <= cur_reg;
            out_chg_reg   <= chg_reg;
            out_done_reg  <= fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            last_reg      <= '0;
            dir_reg       <= '0;
            loop_reg      <= 1'b0;
            step_reg      <= '0;
            cur_reg       <= '0;
            sst_reg       <= '0;
            fin_reg       <= 1'b0;
            play_reg      <= 1'b0;
            chg_reg       <= 1'b0;
            per_valid_reg <= 1'b0;
            acc_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    sas_pkg::REG_FIRST: first_reg <= cfg_data;
                    sas_pkg::REG_LAST:  last_reg  <= cfg_data;
                    sas_pkg::REG_DIR:   dir_reg   <= cfg_data[1:0];
                    sas_pkg::REG_LOOP:  loop_reg  <= cfg_data[0];
                    default: ;
                endcase
            end

            if (ctl.capture)
            begin
                chg_reg <= 1'b0;
            end

            if (ctl.do_play)
            begin
                play_reg <= 1'b1;
                fin_reg  <= 1'b0;
                step_reg <= '0;
                cur_reg  <= start_frame;
                sst_reg  <= now_reg;
            end

            if (ctl.chk && !stop)
            begin
                sst_reg <= sst_reg + {16'd0, dur_cur};
                if (wrap_end && !loop_reg)
                begin
                    fin_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= next_step;
                    cur_reg  <= next_frame;
                    if (next_frame != cur_reg)
                    begin
                        chg_reg <= 1'b1;
                    end
                end
            end

            if (ctl.skip_apply)
            begin
                sst_reg <= now_reg - {7'd0, rem_reg};
                if (step_cnt > 10'd1)
                begin
                    chg_reg <= 1'b1;
                end
            end

            acc_pend_reg <= ctl.per_issue;
            if (ctl.per_clr || cfg_we || ctl.do_write)
            begin
                per_valid_reg <= 1'b0;
            end
            else if (ctl.per_done)
            begin
                per_valid_reg <= 1'b1;
            end

            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;
    assign out_chg   = out_chg_reg;
    assign out_done  = out_done_reg;

endmodule

/* design/sprite_animation_sequencer.sv */
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: now_ms, table_index,
//                                             table_duration
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: frame_out, frame_changed, done_res
// cfg       in   cfg_we (no wait)             cfg_index, cfg_data
//
// Play, table write, unknown commands and ticks while stopped go from dispatch
// straight to the result register; a running tick checks the current frame and does
// one table read per elapsed frame. On a looping tag the first advance of a tick adds
// a period sum (one table read per step, skipped while the cached sum is still
// current) and, when a whole period has elapsed, a restoring remainder divide.
// Reset: rst_n clears playback state and config; the duration table is not
// cleared and must be written before its entries are shown.
// Stalls: a result waits in the output register; the next input beat is taken
// meanwhile, and the block stalls only when a second result is ready.
module sprite_animation_sequencer #(
    parameter int FRAME_COUNT = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    // configuration writes, only while no beat is in flight
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // [31:0] now_ms, [39:32] table_index,
                                        // [55:40] table_duration
    input  logic [1:0]  s_axis_tuser,   // [1:0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] frame_out, [8] frame_changed,
                                        // [9] done_res, [15:10] zero
);

    sas_pkg::sas_cmd_t  ctl;
    sas_pkg::sas_stat_t sts;

    logic [7:0] frame_out;
    logic       frame_changed;
    logic       done_res;

    // sequencer: dispatch, catch-up loop, period skip, result handoff
    sas_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // config, playback state, duration table, period sum, divider, result beat
    sas_dpath #(
        .FRAME_COUNT (FRAME_COUNT)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_cmd    (s_axis_tuser),
        .in_now    (s_axis_tdata[31:0]),
        .in_idx    (s_axis_tdata[39:32]),
        .in_dur    (s_axis_tdata[55:40]),
        .ctl       (ctl),
        .sts       (sts),
        .out_ready (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_frame (frame_out),
        .out_chg   (frame_changed),
        .out_done  (done_res)
    );

    assign m_axis_tdata = {6'd0, done_res, frame_changed, frame_out};

endmodule
